[rtl/u8d_pkg.sv]
// Shared types, constants and the sequence check for the UTF-8 stream decoder.
// No dependencies; used by every module under rtl/.
package u8d_pkg;

	localparam int unsigned CpW   = 21;
	localparam int unsigned UsedW = 3;

	localparam logic [CpW-1:0] CpRepl    = 21'h00FFFD;
	localparam logic [CpW-1:0] CpSurLo   = 21'h00D800;
	localparam logic [CpW-1:0] CpSurHi   = 21'h00DFFF;
	localparam logic [CpW-1:0] CpMax     = 21'h10FFFF;
	localparam logic [CpW-1:0] CpMax1    = 21'h00007F;
	localparam logic [CpW-1:0] CpMax2    = 21'h0007FF;
	localparam logic [CpW-1:0] CpMax3    = 21'h00FFFF;

	localparam logic [UsedW-1:0] Len1 = 3'd1;
	localparam logic [UsedW-1:0] Len2 = 3'd2;
	localparam logic [UsedW-1:0] Len3 = 3'd3;
	localparam logic [UsedW-1:0] Len4 = 3'd4;

	// Results that one byte causes: rep_cnt single-byte replacements,
	// then an optional final result.
	typedef struct packed {
		logic [1:0]       rep_cnt;
		logic             fin_valid;
		logic [CpW-1:0]   fin_cp;
		logic [UsedW-1:0] fin_used;
		logic             fin_rep;
	} burst_t;

	// Overlong form, surrogate or value beyond the code space.
	function automatic logic is_rejected(input logic [CpW-1:0] v, input logic [UsedW-1:0] len);
		logic r;
		r = 1'b0;
		if (len == Len2 && v <= CpMax1) r = 1'b1;
		if (len == Len3 && v <= CpMax2) r = 1'b1;
		if (len == Len4 && v <= CpMax3) r = 1'b1;
		if (v >= CpSurLo && v <= CpSurHi) r = 1'b1;
		if (v > CpMax) r = 1'b1;
		return r;
	endfunction

endpackage

[rtl/u8d_step.sv]
// Sequence state and per-byte decode: turns one byte into a result burst.
// Depends on u8d_pkg.
module u8d_step (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                advance,
	input  logic [7:0]          in_byte,
	output u8d_pkg::burst_t     burst
);

	logic [2:0]                 seq_len_q;
	logic [1:0]                 seq_rcv_q;
	logic [u8d_pkg::CpW-1:0]    partial_q;
	logic [2:0]                 seq_len_d;
	logic [1:0]                 seq_rcv_d;
	logic [u8d_pkg::CpW-1:0]    partial_d;
	logic [2:0]                 rcv_inc;
	logic [u8d_pkg::CpW-1:0]    pv_new;
	logic                       pending;
	logic                       cont;

	assign pending = (seq_len_q != 3'd0);
	assign cont    = (in_byte[7:6] == 2'b10);
	assign rcv_inc = {1'b0, seq_rcv_q} + 3'd1;
	assign pv_new  = {partial_q[u8d_pkg::CpW-7:0], in_byte[5:0]};

	always_comb begin
		burst     = '0;
		seq_len_d = seq_len_q;
		seq_rcv_d = seq_rcv_q;
		partial_d = partial_q;
		if (pending && cont) begin
			if (rcv_inc >= seq_len_q) begin
				// sequence complete: check and release
				burst.fin_valid = 1'b1;
				burst.fin_used  = seq_len_q;
				if (u8d_pkg::is_rejected(pv_new, seq_len_q)) begin
					burst.fin_cp  = u8d_pkg::CpRepl;
					burst.fin_rep = 1'b1;
				end else begin
					burst.fin_cp  = pv_new;
				end
				seq_len_d = 3'd0;
				seq_rcv_d = 2'd0;
				partial_d = '0;
			end else begin
				seq_rcv_d = rcv_inc[1:0];
				partial_d = pv_new;
			end
		end else begin
			// broken sequence: one replacement per byte already taken
			if (pending) begin
				burst.rep_cnt = seq_rcv_q;
			end
			seq_len_d = 3'd0;
			seq_rcv_d = 2'd0;
			partial_d = '0;
			if (in_byte[7] == 1'b0) begin
				burst.fin_valid = 1'b1;
				burst.fin_cp    = {13'd0, in_byte};
				burst.fin_used  = u8d_pkg::Len1;
			end else if (in_byte[7:5] == 3'b110) begin
				seq_len_d = u8d_pkg::Len2;
				seq_rcv_d = 2'd1;
				partial_d = {16'd0, in_byte[4:0]};
			end else if (in_byte[7:4] == 4'b1110) begin
				seq_len_d = u8d_pkg::Len3;
				seq_rcv_d = 2'd1;
				partial_d = {17'd0, in_byte[3:0]};
			end else if (in_byte[7:3] == 5'b11110) begin
				seq_len_d = u8d_pkg::Len4;
				seq_rcv_d = 2'd1;
				partial_d = {18'd0, in_byte[2:0]};
			end else begin
				burst.fin_valid = 1'b1;
				burst.fin_cp    = u8d_pkg::CpRepl;
				burst.fin_used  = u8d_pkg::Len1;
				burst.fin_rep   = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_len_q <= 3'd0;
			seq_rcv_q <= 2'd0;
			partial_q <= '0;
		end else if (advance) begin
			seq_len_q <= seq_len_d;
			seq_rcv_q <= seq_rcv_d;
			partial_q <= partial_d;
		end
	end

endmodule

[rtl/u8d_burst.sv]
// Result register: holds a burst, hands out one result per cycle on cp_ready.
// Depends on u8d_pkg.
module u8d_burst (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        load,
	input  u8d_pkg::burst_t             burst,
	output logic                        can_load,
	output logic                        cp_valid,
	input  logic                        cp_ready,
	output logic [u8d_pkg::CpW-1:0]     code_point,
	output logic [u8d_pkg::UsedW-1:0]   bytes_used,
	output logic                        replaced,
	output logic                        last
);

	logic [1:0]                   rep_cnt_q;
	logic                         fin_valid_q;
	logic [u8d_pkg::CpW-1:0]      fin_cp_q;
	logic [u8d_pkg::UsedW-1:0]    fin_used_q;
	logic                         fin_rep_q;
	logic                         take;

	assign cp_valid   = (rep_cnt_q != 2'd0) || fin_valid_q;
	assign last       = (rep_cnt_q == 2'd0) || ((rep_cnt_q == 2'd1) && !fin_valid_q);
	assign code_point = (rep_cnt_q != 2'd0) ? u8d_pkg::CpRepl : fin_cp_q;
	assign bytes_used = (rep_cnt_q != 2'd0) ? u8d_pkg::Len1 : fin_used_q;
	assign replaced   = (rep_cnt_q != 2'd0) ? 1'b1 : fin_rep_q;
	assign take       = cp_valid && cp_ready;
	assign can_load   = !cp_valid || (take && last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rep_cnt_q   <= 2'd0;
			fin_valid_q <= 1'b0;
		end else if (load) begin
			rep_cnt_q   <= burst.rep_cnt;
			fin_valid_q <= burst.fin_valid;
		end else if (take) begin
			if (rep_cnt_q != 2'd0) begin
				rep_cnt_q <= rep_cnt_q - 2'd1;
			end else begin
				fin_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			fin_cp_q   <= burst.fin_cp;
			fin_used_q <= burst.fin_used;
			fin_rep_q  <= burst.fin_rep;
		end
	end

endmodule

[rtl/utf8_stream_decoder.sv]
// Top level of the UTF-8 stream decoder: input register, decode step, result burst.
// Depends on u8d_pkg, u8d_step and u8d_burst.
//
//  channel | signals                                   | item
//  --------+-------------------------------------------+------------------------------
//  byte    | byte_valid, byte_ready, in_byte           | one raw stream byte
//  cp      | cp_valid, cp_ready, code_point,           | one decoded code point or
//          | bytes_used, replaced, last                | replacement; last ends a byte
//
// One byte per cycle in steady state; a byte passes through the input register and
// the result register before its first result appears. A byte that breaks a pending
// sequence makes up to four results, and the result register hands these out one
// per cycle while cp_ready is high, so the byte path stalls until the last is taken.
// arst_n clears the input valid, the sequence state and the result register's valid state.
// A stalled cp channel backs up through the input register to byte_ready.
module utf8_stream_decoder (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        byte_valid,
	output logic                        byte_ready,
	input  logic [7:0]                  in_byte,
	output logic                        cp_valid,
	input  logic                        cp_ready,
	output logic [u8d_pkg::CpW-1:0]     code_point,
	output logic [u8d_pkg::UsedW-1:0]   bytes_used,
	output logic                        replaced,
	output logic                        last
);

	logic              valid_s1;
	logic [7:0]        byte_s1;
	logic              can_load;
	logic              advance;
	u8d_pkg::burst_t   burst;

	// Move the held byte into decode whenever the result register can take it.
	assign advance    = valid_s1 && can_load;
	assign byte_ready = !valid_s1 || can_load;

	// Input register: hold the byte until decode takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_ready) begin
			valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_valid && byte_ready) begin
			byte_s1 <= in_byte;
		end
	end

	// Decode one byte against the pending sequence; advance state on accept.
	u8d_step u_step (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.in_byte (byte_s1),
		.burst   (burst)
	);

	// Drain the burst one result per cycle while cp_ready is high.
	u8d_burst u_burst (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (advance),
		.burst      (burst),
		.can_load   (can_load),
		.cp_valid   (cp_valid),
		.cp_ready   (cp_ready),
		.code_point (code_point),
		.bytes_used (bytes_used),
		.replaced   (replaced),
		.last       (last)
	);

	// A burst never breaks off before its last result.
	a_burst_continues: assert property (@(posedge clk) disable iff (!arst_n)
		cp_valid && !last |=> cp_valid)
		else $error("burst ended without a last result");

	// Every result ahead of the last one is a single-byte replacement.
	a_lead_repl: assert property (@(posedge clk) disable iff (!arst_n)
		cp_valid && !last |-> replaced && code_point == u8d_pkg::CpRepl
			&& bytes_used == u8d_pkg::Len1)
		else $error("non-final result is not a one-byte replacement");

	// An accepted code point is a scalar value.
	a_scalar: assert property (@(posedge clk) disable iff (!arst_n)
		cp_valid && !replaced |-> code_point <= u8d_pkg::CpMax
			&& (code_point < u8d_pkg::CpSurLo || code_point > u8d_pkg::CpSurHi))
		else $error("decoded value outside the scalar range");

endmodule
